// ----- design/cpvpid_pkg.sv -----
// ----------------------------------------------------------------------------
// cpvpid_pkg: shared types and constants
// Register indexes, controller commands, window size and fixed-point limits.
// ----------------------------------------------------------------------------
`default_nettype none
package cpvpid_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_POS_GAIN     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_VEL_P_GAIN   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_VEL_I_GAIN   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_VEL_D_GAIN   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_DUTY_FLOOR   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_DUTY_CEILING = 3'd6;

    localparam int SpeedWindow = 8;

    localparam logic signed [63:0] IntegralMax = 64'sd1677721600;
    localparam logic signed [63:0] Q24Hundred  = 64'sd1677721600;
    localparam logic signed [33:0] Deadband    = 34'sd26;

    typedef struct packed {
        logic load;   // take input, update ring and position loop
        logic s1;     // speed error, derivative delta, divide by five
        logic s2;     // derivative filter, divide by twenty-five
        logic s3;     // integral, P and D products
        logic s4;     // I product
        logic s5;     // sum and output
    } t_cmd;

    typedef struct packed {
        logic [23:0] pos_gain;
        logic [23:0] vel_p_gain;
        logic [23:0] vel_i_gain;
        logic [23:0] vel_d_gain;
        logic [30:0] speed_limit;
        logic [15:0] duty_floor;
        logic [15:0] duty_ceiling;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- design/cpvpid_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpvpid_ctrl: sequencing controller
// One-hot state machine stepping one tick through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module cpvpid_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_fire,
    input  wire logic            i_out_busy,
    output cpvpid_pkg::t_cmd     o_cmd,
    output logic                 o_in_ready
);
    import cpvpid_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_S1   = 6'b000010,
        ST_S2   = 6'b000100,
        ST_S3   = 6'b001000,
        ST_S4   = 6'b010000,
        ST_WAIT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_fire) n_state = ST_S1;
            ST_S1:   n_state = ST_S2;
            ST_S2:   n_state = ST_S3;
            ST_S3:   n_state = ST_S4;
            ST_S4:   n_state = ST_WAIT;
            ST_WAIT: if (!i_out_busy) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd.load = i_in_fire;
    assign o_cmd.s1   = (r_state == ST_S1);
    assign o_cmd.s2   = (r_state == ST_S2);
    assign o_cmd.s3   = (r_state == ST_S3);
    assign o_cmd.s4   = (r_state == ST_S4);
    assign o_cmd.s5   = (r_state == ST_WAIT) && !i_out_busy;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |-> r_state == ST_IDLE) else $error("load outside idle");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |=> r_state == ST_S1) else $error("sequence broken");
`endif
endmodule
`default_nettype wire

// ----- design/cpvpid_dp.sv -----
// ----------------------------------------------------------------------------
// cpvpid_dp: controller datapath
// Velocity ring, position loop, velocity PID and PWM output stage.
// ----------------------------------------------------------------------------
`default_nettype none
module cpvpid_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  cpvpid_pkg::t_cmd         i_cmd,
    input  cpvpid_pkg::t_cfg         i_cfg,
    input  wire logic signed [31:0]  i_meas,
    input  wire logic signed [31:0]  i_goal,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic                     o_drive_a,
    output logic                     o_drive_b,
    output logic [15:0]              o_duty,
    output logic signed [31:0]       o_speed_est,
    output logic signed [31:0]       o_speed_cmd
);
    import cpvpid_pkg::*;

    localparam int unsigned SlotW = (SpeedWindow > 1) ? $clog2(SpeedWindow) : 1;
    localparam int unsigned TotW  = 32 + SlotW + 1;
    localparam logic [31:0] Recip5  = 32'hCCCC_CCCD;
    localparam logic [31:0] Recip25 = 32'h51EB_851F;

    logic signed [31:0] r_ring [SpeedWindow];
    logic [SlotW-1:0]   r_slot;
    logic signed [TotW-1:0] r_total;
    logic signed [31:0] r_prior_pos, r_integral, r_prior_err, r_fder;
    logic signed [31:0] r_est, r_cmd, r_err;
    logic signed [32:0] r_dlt;
    logic [29:0]        r_fq;
    logic [28:0]        r_eq;
    logic               r_dead;
    logic signed [63:0] r_pterm, r_dterm, r_iterm;
    logic               r_valid;
    logic               r_a, r_b;
    logic [15:0]        r_duty;
    logic signed [31:0] r_out_est, r_out_cmd;

    logic signed [63:0] raw64, cmd64, lim64, acc, fd, nsum, flo, fhi, q4, inc;
    logic signed [63:0] u, mag, span;
    logic signed [33:0] epos;
    logic signed [31:0] raw_vel, err_s;
    logic signed [TotW-1:0] tot_n;
    logic [31:0]        f_abs, e_abs, frem, erem;
    logic [63:0]        fq_prod, eq_prod, fr_prod;
    logic [2:0]         fb, fbm1;
    logic [12:0]        frac;
    logic [41:0]        imag;
    logic               dead_n;

    always_comb begin
        raw64   = (64'(i_meas) - 64'(r_prior_pos)) * 64'sd100;
        raw_vel = sat32(raw64);
        tot_n   = r_total + TotW'(raw_vel) - TotW'(r_ring[r_slot]);
        epos    = 34'(i_goal) - 34'(i_meas);
        cmd64   = (64'(epos) * $signed({40'd0, i_cfg.pos_gain})) / 64'sd65536;
        lim64   = $signed({33'd0, i_cfg.speed_limit});
        if (cmd64 > lim64) cmd64 = lim64;
        if (cmd64 < -lim64) cmd64 = -lim64;
        dead_n  = (epos < Deadband) && (epos > -Deadband);
        err_s   = sat32(64'(r_cmd) - 64'(r_est));
        // |f| / 5 and |e| / 25 by reciprocal multiplication
        f_abs   = r_fder[31] ? 32'(-r_fder) : 32'(r_fder);
        fq_prod = 64'(f_abs) * 64'(Recip5);
        e_abs   = r_err[31] ? 32'(-r_err) : 32'(r_err);
        eq_prod = 64'(e_abs) * 64'(Recip25);
        // 4f/5 rounded down and up from |f| = 5q + b
        frem    = f_abs - 32'(r_fq) * 32'd5;
        fb      = frem[2:0];
        fbm1    = (fb != 3'd0) ? fb - 3'd1 : 3'd0;
        q4      = $signed(64'({r_fq, 2'b00}));
        if (!r_fder[31]) begin
            flo = q4 + $signed(64'(fbm1));
            fhi = q4 + $signed(64'(fb));
        end else begin
            flo = -(q4 + $signed(64'(fb)));
            fhi = -(q4 + $signed(64'(fbm1)));
        end
        nsum    = 64'sd4 * 64'(r_fder) + 64'(r_dlt) * 64'sd100;
        fd      = 64'(r_dlt) * 64'sd20 + ((nsum < 0) ? fhi : flo);
        // |e| * 8192 / 25 from |e| = 25q + r
        erem    = e_abs - 32'(r_eq) * 32'd25;
        fr_prod = 64'(erem[4:0]) * 64'(Recip25);
        frac    = fr_prod[34:22];
        imag    = {r_eq, frac};
        inc     = r_err[31] ? -$signed(64'(imag)) : $signed(64'(imag));
        acc     = (r_dead ? 64'sd0 : 64'(r_integral)) + inc;
        if (acc > IntegralMax) acc = IntegralMax;
        if (acc < -IntegralMax) acc = -IntegralMax;
        u       = r_pterm + r_iterm + r_dterm;
        mag     = (u < 0) ? -u : u;
        span    = (i_cfg.duty_ceiling > i_cfg.duty_floor)
                ? 64'(i_cfg.duty_ceiling - i_cfg.duty_floor) : 64'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SpeedWindow; k++) r_ring[k] <= '0;
            r_slot <= '0; r_total <= '0; r_prior_pos <= '0;
            r_integral <= '0; r_prior_err <= '0; r_fder <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ring[r_slot] <= raw_vel;
                r_slot <= (32'(r_slot) == SpeedWindow - 1) ? '0 : r_slot + 1'b1;
                r_total <= tot_n;
                r_prior_pos <= i_meas;
                r_est <= 32'(tot_n / TotW'(SpeedWindow));
                r_dead <= dead_n;
                r_cmd <= dead_n ? 32'sd0 : cmd64[31:0];
            end
            if (i_cmd.s1) begin
                r_err <= err_s;
                r_prior_err <= err_s;
                r_dlt <= 33'(err_s) - 33'(r_prior_err);
                r_fq <= fq_prod[63:34];
            end
            if (i_cmd.s2) begin
                r_eq <= eq_prod[63:35];
                r_fder <= sat32(fd);
            end
            if (i_cmd.s3) begin
                r_integral <= acc[31:0];
                r_pterm <= 64'(r_err) * $signed({40'd0, i_cfg.vel_p_gain});
                r_dterm <= 64'(r_fder) * $signed({40'd0, i_cfg.vel_d_gain});
            end
            if (i_cmd.s4) begin
                r_iterm <= (64'(r_integral) * $signed({40'd0, i_cfg.vel_i_gain}))
                           / 64'sd32768;
            end
            if (i_cmd.s5) begin
                r_valid <= 1'b1;
                r_out_est <= r_est;
                r_out_cmd <= r_cmd;
                r_a <= 1'b0; r_b <= 1'b0; r_duty <= '0;
                if (mag > Q24Hundred) begin
                    r_a <= (u > 0);
                    r_b <= !(u > 0);
                    r_duty <= i_cfg.duty_floor
                            + (((mag >>> 24) > span) ? span[15:0] : mag[39:24]);
                end
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_drive_a   = r_a;
    assign o_drive_b   = r_b;
    assign o_duty      = r_duty;
    assign o_speed_est = r_out_est;
    assign o_speed_cmd = r_out_cmd;

`ifndef SYNTHESIS
    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_a && r_b)) else $error("both drive pins set");
    a_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_a && !r_b) |-> r_duty == 16'd0) else $error("duty while braking");
    a_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        64'(r_integral) <= IntegralMax && 64'(r_integral) >= -IntegralMax)
        else $error("integral out of range");
`endif
endmodule
`default_nettype wire

// ----- design/cascaded_position_velocity_pid.sv -----
// Sequencing: an accepted request steps through S1, S2, S3, S4 and WAIT; the result
// registers on leaving WAIT once the output is free. No new request is taken until idle.
// Reset: synchronous active low; clears history, ring, integral and registers.
// Result waits in an output register; a new request is taken while it waits.
// ----------------------------------------------------------------------------
// cascaded_position_velocity_pid: position/velocity cascade controller
// Streaming wrapper with configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module cascaded_position_velocity_pid (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // measured_position, goal_position
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,  // drive_a, drive_b, duty, speed_estimate,
                                            // speed_command, 6 zero bits
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import cpvpid_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    logic in_fire, a, b;
    logic [15:0] duty;
    logic signed [31:0] est, scmd;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{default: '0, duty_ceiling: 16'hffff};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_POS_GAIN:     r_cfg.pos_gain     <= i_cfg_data[23:0];
                REG_VEL_P_GAIN:   r_cfg.vel_p_gain   <= i_cfg_data[23:0];
                REG_VEL_I_GAIN:   r_cfg.vel_i_gain   <= i_cfg_data[23:0];
                REG_VEL_D_GAIN:   r_cfg.vel_d_gain   <= i_cfg_data[23:0];
                REG_SPEED_LIMIT:  r_cfg.speed_limit  <= i_cfg_data[30:0];
                REG_DUTY_FLOOR:   r_cfg.duty_floor   <= i_cfg_data[15:0];
                REG_DUTY_CEILING: r_cfg.duty_ceiling <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    cpvpid_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire),
        .i_out_busy(m_axis_tvalid && !m_axis_tready),
        .o_cmd(cmd), .o_in_ready(s_axis_tready)
    );

    cpvpid_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cfg(r_cfg),
        .i_meas(s_axis_tdata[31:0]), .i_goal(s_axis_tdata[63:32]),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_drive_a(a), .o_drive_b(b), .o_duty(duty),
        .o_speed_est(est), .o_speed_cmd(scmd)
    );

    assign m_axis_tdata = {6'd0, scmd, est, duty, b, a};
endmodule
`default_nettype wire
